// ===== sv/two_sensor_direction_counter_unit_macros.svh =====
// Assertion helpers for the file that checks this block.
// Both expect clk and rst in scope.
`ifndef TWO_SENSOR_DIRECTION_COUNTER_UNIT_MACROS_SVH
`define TWO_SENSOR_DIRECTION_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication.
`define TSDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TSDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/tsdc_pkg.sv =====
`default_nettype none

package tsdc_pkg;

  // Operation codes
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_EQUALIZE  = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_SET_COUNT = 2'd3
  } op_t;

  // Event codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_EXIT  = 2'd2
  } ev_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_THRESHOLD      = 2'd0;
  localparam logic [1:0] CFG_MOTION_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_PAIR_TIMEOUT   = 2'd2;

  localparam logic [31:0] RST_THRESHOLD      = 32'd0;
  localparam logic [7:0]  RST_MOTION_TIMEOUT = 8'd10;
  localparam logic [7:0]  RST_PAIR_TIMEOUT   = 8'd20;

  localparam logic [31:0] LOW_BYTE_BUMP = 32'd256;
  localparam logic [3:0]  MAX_COUNT     = 4'd9;

  typedef struct packed {
    op_t         opcode;
    logic [23:0] osc0_count;
    logic [31:0] osc1_count;
    logic [3:0]  digit;
  } cmd_t;

  typedef struct packed {
    logic [31:0]        adjusted_osc0;
    logic [31:0]        osc1_value;
    ev_t                event_res;
    logic [3:0]         count;
    logic [6:0]         segments;
    logic signed [31:0] offset_value;
  } rsp_t;

  typedef struct packed {
    logic [31:0] detect_threshold;
    logic [7:0]  motion_timeout;
    logic [7:0]  pair_timeout;
  } cfg_t;

  // Seven-segment pattern, bit0 = segment a
  function automatic logic [6:0] seg_pattern(input logic [3:0] value);
    logic [6:0] pat;
    case (value)
      4'd0: pat = 7'b0111111;
      4'd1: pat = 7'b0000110;
      4'd2: pat = 7'b1011011;
      4'd3: pat = 7'b1001111;
      4'd4: pat = 7'b1100110;
      4'd5: pat = 7'b1101101;
      4'd6: pat = 7'b1111101;
      4'd7: pat = 7'b0000111;
      4'd8: pat = 7'b1111111;
      4'd9: pat = 7'b1101111;
      default: pat = 7'b0000000;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tsdc_cfg_regs.sv =====
`default_nettype none

module tsdc_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  output tsdc_pkg::cfg_t         cfg
);

  // Register file; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_threshold <= tsdc_pkg::RST_THRESHOLD;
      cfg.motion_timeout   <= tsdc_pkg::RST_MOTION_TIMEOUT;
      cfg.pair_timeout     <= tsdc_pkg::RST_PAIR_TIMEOUT;
    end else if (cfg_valid) begin
      case (cfg_index)
        tsdc_pkg::CFG_THRESHOLD:      cfg.detect_threshold <= cfg_data;
        tsdc_pkg::CFG_MOTION_TIMEOUT: cfg.motion_timeout   <= cfg_data[7:0];
        tsdc_pkg::CFG_PAIR_TIMEOUT:   cfg.pair_timeout     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/tsdc_core.sv =====
`default_nettype none

module tsdc_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire tsdc_pkg::cmd_t cmd,
  input  wire tsdc_pkg::cfg_t cfg,
  output tsdc_pkg::rsp_t      rsp
);

  logic [1:0]  first_flags,  first_flags_next;
  logic [1:0]  motion_flags, motion_flags_next;
  logic [7:0]  motion_timer, motion_timer_next;
  logic [7:0]  pair_timer,   pair_timer_next;
  logic [3:0]  people_count, people_count_next;
  logic [31:0] offset,       offset_next;
  logic [31:0] last_osc0,    last_osc0_next;
  logic [31:0] last_osc1,    last_osc1_next;
  tsdc_pkg::ev_t ev;

  logic [31:0] adj0;
  logic        trig0, trig1;

  // Corrected sensor 0 and trigger compares
  always_comb begin
    adj0 = 32'(cmd.osc0_count) + offset +
           ((cmd.osc0_count[7:0] == 8'd0) ? tsdc_pkg::LOW_BYTE_BUMP : 32'd0);
    trig0 = adj0 < cfg.detect_threshold;
    trig1 = cmd.osc1_count < cfg.detect_threshold;
  end

  // Next state for one transaction
  always_comb begin
    first_flags_next  = first_flags;
    motion_flags_next = motion_flags;
    motion_timer_next = motion_timer;
    pair_timer_next   = pair_timer;
    people_count_next = people_count;
    offset_next       = offset;
    last_osc0_next    = last_osc0;
    last_osc1_next    = last_osc1;
    ev                = tsdc_pkg::EV_NONE;

    case (cmd.opcode)
      tsdc_pkg::OP_TICK: begin
        last_osc0_next = adj0;
        last_osc1_next = cmd.osc1_count;

        // timeouts
        if (motion_flags != 2'b00) begin
          motion_timer_next = motion_timer + 8'd1;
        end
        if (motion_timer_next > cfg.motion_timeout) begin
          motion_flags_next = 2'b00;
          motion_timer_next = 8'd0;
        end
        if (first_flags != 2'b00) begin
          pair_timer_next = pair_timer + 8'd1;
        end
        if (pair_timer_next > cfg.pair_timeout) begin
          pair_timer_next  = 8'd0;
          first_flags_next = 2'b00;
        end

        // sensor 0: exit when sensor 1 was first
        if (trig0) begin
          if (!first_flags_next[1]) begin
            first_flags_next[0] = 1'b1;
          end else if (!trig1) begin
            motion_timer_next = 8'd0;
            if (!motion_flags_next[0]) begin
              if (people_count_next != 4'd0) begin
                people_count_next = people_count_next - 4'd1;
              end
              ev = tsdc_pkg::EV_EXIT;
            end
            motion_flags_next[0] = 1'b1;
          end
        end

        // sensor 1: enter when sensor 0 was first
        if (trig1) begin
          if (!first_flags_next[0]) begin
            first_flags_next[1] = 1'b1;
          end else if (!trig0) begin
            motion_timer_next = 8'd0;
            if (!motion_flags_next[1]) begin
              if (people_count_next < tsdc_pkg::MAX_COUNT) begin
                people_count_next = people_count_next + 4'd1;
              end
              ev = tsdc_pkg::EV_ENTER;
            end
            motion_flags_next[1] = 1'b1;
          end
        end
      end
      tsdc_pkg::OP_EQUALIZE: begin
        offset_next = offset + last_osc1 - last_osc0;
      end
      tsdc_pkg::OP_CLEAR: begin
        offset_next = 32'd0;
      end
      tsdc_pkg::OP_SET_COUNT: begin
        if (cmd.digit <= tsdc_pkg::MAX_COUNT) begin
          people_count_next = cmd.digit;
        end
      end
      default: ;
    endcase
  end

  // Result fields
  always_comb begin
    rsp.adjusted_osc0 = last_osc0_next;
    rsp.osc1_value    = last_osc1_next;
    rsp.event_res     = ev;
    rsp.count         = people_count_next;
    rsp.segments      = tsdc_pkg::seg_pattern(people_count_next);
    rsp.offset_value  = signed'(offset_next);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_flags  <= 2'b00;
      motion_flags <= 2'b00;
      motion_timer <= 8'd0;
      pair_timer   <= 8'd0;
      people_count <= 4'd0;
      offset       <= 32'd0;
      last_osc0    <= 32'd0;
      last_osc1    <= 32'd0;
    end else if (en) begin
      first_flags  <= first_flags_next;
      motion_flags <= motion_flags_next;
      motion_timer <= motion_timer_next;
      pair_timer   <= pair_timer_next;
      people_count <= people_count_next;
      offset       <= offset_next;
      last_osc0    <= last_osc0_next;
      last_osc1    <= last_osc1_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/two_sensor_direction_counter_unit.sv =====
// Channel  Direction  Handshake              Payload
// cmd      in         cmd_valid / cmd_stall  tsdc_pkg::cmd_t
// rsp      out        rsp_valid / rsp_stall  tsdc_pkg::rsp_t
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One command per cycle while cmd_stall is low; the command register holds an accepted
// command, then the response register holds its response, set by the single state update.
// Synchronous reset clears state, timers, offset and loads register defaults.
// A stalled response holds the command register; cmd_stall rises only then.
// cfg_ready is always high.
`default_nettype none

`include "two_sensor_direction_counter_unit_macros.svh"

module two_sensor_direction_counter_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire tsdc_pkg::cmd_t cmd,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output tsdc_pkg::rsp_t      rsp,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [31:0]    cfg_data
);

  logic           hold_valid;
  tsdc_pkg::cmd_t hold_cmd;
  logic           advance;
  tsdc_pkg::cfg_t cfg;
  tsdc_pkg::rsp_t core_rsp;

  assign cfg_ready = 1'b1;

  // Handshake control
  assign advance   = hold_valid & (~rsp_valid | ~rsp_stall);
  assign cmd_stall = hold_valid & ~advance;

  tsdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tsdc_core u_core (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .cmd (hold_cmd),
    .cfg (cfg),
    .rsp (core_rsp)
  );

  // Command register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!cmd_stall) begin
      hold_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      hold_cmd <= cmd;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= core_rsp;
    end
  end

  // Checks
  `TSDC_ASSERT_NOW(a_no_overrun, hold_valid && rsp_valid && rsp_stall, cmd_stall, "command overrun")
  `TSDC_ASSERT_NEXT(a_advance_shows, advance, rsp_valid, "advanced command lost")
  `TSDC_ASSERT_NOW(a_enter_count, rsp_valid && rsp.event_res == tsdc_pkg::EV_ENTER, rsp.count != 4'd0, "enter with zero count")
  `TSDC_ASSERT_NOW(a_exit_count, rsp_valid && rsp.event_res == tsdc_pkg::EV_EXIT, rsp.count != tsdc_pkg::MAX_COUNT, "exit with full count")

endmodule

`default_nettype wire
